// ===== src/qoa_pkg.sv =====
// package: shared types and constants for the quaternion orientation accumulator
`timescale 1ns / 1ps
`default_nettype none
package qoa_pkg;

  // controller states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_LOAD,
    ST_COMP,
    ST_CWB,
    ST_SUMSQ,
    ST_SQRT,
    ST_DIV,
    ST_MAT,
    ST_OUT
  } qoa_state_t;

  // datapath commands from the controller
  typedef struct packed {
    logic       spin_q;
    logic       load_q;
    logic       comp_step;
    logic [3:0] comp_idx;
    logic       comp_wb;
    logic       sumsq_step;
    logic [1:0] sumsq_idx;
    logic       sqrt_init;
    logic       sqrt_step;
    logic       div_init;
    logic       div_step;
    logic [1:0] div_idx;
    logic       div_wb;
    logic       mat_step;
    logic [3:0] mat_idx;
    logic       row_load;
    logic [1:0] row_sel;
  } qoa_cmd_t;

  // datapath status to the controller
  typedef struct packed {
    logic mag_zero;
    logic div_done;
  } qoa_stat_t;

  localparam int unsigned SUM_W = 34;
  localparam int unsigned ROOT_W = 17;
  localparam int unsigned SQRT_STEPS = 17;

endpackage
`default_nettype wire

// ===== src/qoa_datapath.sv =====
// datapath: shared multiplier, accumulators, square root and divider
`timescale 1ns / 1ps
`default_nettype none
module qoa_datapath #(
  parameter int FRAC_BITS = 14
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire qoa_pkg::qoa_cmd_t cmd,
  output qoa_pkg::qoa_stat_t   stat,
  input  wire logic signed [15:0] in_x,
  input  wire logic signed [15:0] in_y,
  input  wire logic signed [15:0] in_z,
  input  wire logic signed [15:0] in_w,
  output logic signed [15:0]   row_c0,
  output logic signed [15:0]   row_c1,
  output logic signed [15:0]   row_c2
);
  import qoa_pkg::*;

  localparam int DIV_W = 16 + FRAC_BITS + 1;
  localparam int CNT_W = $clog2(DIV_W + 1);
  localparam int ENT_W = (2 * FRAC_BITS + 3 > 35) ? 2 * FRAC_BITS + 3 : 35;
  localparam logic signed [63:0] HALF = 64'sd1 <<< (FRAC_BITS - 1);
  localparam logic signed [63:0] ONE2 = 64'sd1 <<< (2 * FRAC_BITS);
  localparam logic signed [63:0] ONE = 64'sd1 <<< FRAC_BITS;

  logic signed [15:0] orient [4];
  logic signed [15:0] spin [4];
  logic signed [34:0] acc;
  logic signed [31:0] prod;
  logic signed [15:0] ma, mb;
  logic               msub;
  logic signed [15:0] newq [4];
  logic [SUM_W-1:0]   sumsq;
  logic [SUM_W-1:0]   rem_s;
  logic [ROOT_W-1:0]  root;
  logic [5:0]         sq_cnt;
  logic [DIV_W-1:0]   num;
  logic [DIV_W:0]     drem;
  logic [CNT_W-1:0]   dcnt;
  logic               dneg;
  logic signed [ENT_W-1:0] ent [9];
  logic signed [ENT_W-1:0] e0, e1, e2;

  function automatic logic signed [15:0] rnd(input logic signed [63:0] v);
    logic signed [63:0] s;
    s = (v + HALF) >>> FRAC_BITS;
    if (s > 64'sd32767) return 16'sh7fff;
    if (s < -64'sd32768) return 16'sh8000;
    return s[15:0];
  endfunction

  // operand select for composition products
  always_comb begin
    ma = '0; mb = '0; msub = 1'b0;
    case (cmd.comp_idx)
      4'd0: begin ma = spin[0]; mb = orient[3]; end
      4'd1: begin ma = orient[0]; mb = spin[3]; end
      4'd2: begin ma = orient[1]; mb = spin[2]; end
      4'd3: begin ma = orient[2]; mb = spin[1]; msub = 1'b1; end
      4'd4: begin ma = spin[1]; mb = orient[3]; end
      4'd5: begin ma = orient[1]; mb = spin[3]; end
      4'd6: begin ma = orient[2]; mb = spin[0]; end
      4'd7: begin ma = orient[0]; mb = spin[2]; msub = 1'b1; end
      4'd8: begin ma = spin[2]; mb = orient[3]; end
      4'd9: begin ma = orient[2]; mb = spin[3]; end
      4'd10: begin ma = orient[0]; mb = spin[1]; end
      4'd11: begin ma = orient[1]; mb = spin[0]; msub = 1'b1; end
      4'd12: begin ma = spin[3]; mb = orient[3]; end
      4'd13: begin ma = spin[0]; mb = orient[0]; msub = 1'b1; end
      4'd14: begin ma = spin[1]; mb = orient[1]; msub = 1'b1; end
      default: begin ma = spin[2]; mb = orient[2]; msub = 1'b1; end
    endcase
    if (cmd.sumsq_step) begin
      ma = orient[cmd.sumsq_idx]; mb = orient[cmd.sumsq_idx]; msub = 1'b0;
    end
    if (cmd.mat_step) begin
      msub = 1'b0;
      case (cmd.mat_idx)
        4'd0: begin ma = orient[0]; mb = orient[0]; end
        4'd1: begin ma = orient[1]; mb = orient[1]; end
        4'd2: begin ma = orient[2]; mb = orient[2]; end
        4'd3: begin ma = orient[0]; mb = orient[1]; end
        4'd4: begin ma = orient[2]; mb = orient[3]; end
        4'd5: begin ma = orient[2]; mb = orient[0]; end
        4'd6: begin ma = orient[1]; mb = orient[3]; end
        4'd7: begin ma = orient[1]; mb = orient[2]; end
        default: begin ma = orient[0]; mb = orient[3]; end
      endcase
    end
  end

  // shared multiplier, registered
  always_ff @(posedge clk) begin
    prod <= ma * mb;
  end

  // products held for matrix assembly, with the step flags delayed to match
  logic signed [31:0] mp [9];
  logic               mat_d, step_d, sub_d, sq_d;
  logic [3:0]         idx_d;
  always_ff @(posedge clk) begin
    mat_d <= cmd.mat_step;
    step_d <= cmd.comp_step;
    sq_d <= cmd.sumsq_step;
    sub_d <= msub;
    idx_d <= cmd.mat_step ? cmd.mat_idx : cmd.comp_idx;
    if (mat_d) mp[idx_d] <= prod;
  end

  // matrix entries from held products
  always_comb begin
    ent[0] = ENT_W'(ONE2) - ENT_W'((64'(mp[1]) + 64'(mp[2])) <<< 1);
    ent[1] = ENT_W'((64'(mp[3]) - 64'(mp[4])) <<< 1);
    ent[2] = ENT_W'((64'(mp[5]) + 64'(mp[6])) <<< 1);
    ent[3] = ENT_W'((64'(mp[3]) + 64'(mp[4])) <<< 1);
    ent[4] = ENT_W'(ONE2) - ENT_W'((64'(mp[2]) + 64'(mp[0])) <<< 1);
    ent[5] = ENT_W'((64'(mp[7]) - 64'(mp[8])) <<< 1);
    ent[6] = ENT_W'((64'(mp[5]) - 64'(mp[6])) <<< 1);
    ent[7] = ENT_W'((64'(mp[7]) + 64'(mp[8])) <<< 1);
    ent[8] = ENT_W'(ONE2) - ENT_W'((64'(mp[1]) + 64'(mp[0])) <<< 1);
  end

  // entries of the selected row
  always_comb begin
    case (cmd.row_sel)
      2'd0: begin e0 = ent[0]; e1 = ent[1]; e2 = ent[2]; end
      2'd1: begin e0 = ent[3]; e1 = ent[4]; e2 = ent[5]; end
      default: begin e0 = ent[6]; e1 = ent[7]; e2 = ent[8]; end
    endcase
  end

  // row result registers
  always_ff @(posedge clk) begin
    if (cmd.row_load) begin
      row_c0 <= rnd(64'(e0));
      row_c1 <= rnd(64'(e1));
      row_c2 <= rnd(64'(e2));
    end
  end

  // composition accumulator, four products per component
  always_ff @(posedge clk) begin
    if (step_d) begin
      if (idx_d[1:0] == 2'd0) acc <= 35'(prod);
      else if (sub_d) acc <= acc - 35'(prod);
      else acc <= acc + 35'(prod);
      if (idx_d[1:0] == 2'd3) newq[idx_d[3:2]] <= rnd(64'(sub_d ? acc - 35'(prod)
                                                              : acc + 35'(prod)));
    end
  end

  // sum of squares
  always_ff @(posedge clk) begin
    if (cmd.load_q) sumsq <= '0;
    else if (sq_d) sumsq <= sumsq + SUM_W'(unsigned'(prod));
    else if (cmd.comp_wb) sumsq <= '0;
  end

  // integer square root, one result bit a cycle
  always_ff @(posedge clk) begin
    if (cmd.sqrt_init) begin
      rem_s <= '0; root <= '0; sq_cnt <= '0;
    end else if (cmd.sqrt_step) begin
      logic [SUM_W-1:0] r2;
      r2 = {rem_s[SUM_W-3:0], sumsq[SUM_W-1 - 2*sq_cnt -: 2]};
      if (r2 >= SUM_W'({root, 2'b01})) begin
        rem_s <= r2 - SUM_W'({root, 2'b01});
        root <= {root[ROOT_W-2:0], 1'b1};
      end else begin
        rem_s <= r2;
        root <= {root[ROOT_W-2:0], 1'b0};
      end
      sq_cnt <= sq_cnt + 6'd1;
    end
  end

  // restoring divider: (|q| << F + m/2) / m
  logic signed [15:0] dsrc;
  assign dsrc = orient[cmd.div_idx];
  always_ff @(posedge clk) begin
    if (rst) dcnt <= '0;
    else if (cmd.div_init) begin
      dneg <= dsrc[15];
      num <= DIV_W'((64'(dsrc[15] ? -32'(dsrc) : 32'(dsrc)) <<< FRAC_BITS)
                    + 64'(root >> 1));
      drem <= '0;
      dcnt <= CNT_W'(DIV_W);
    end else if (cmd.div_step && dcnt != '0) begin
      logic [DIV_W:0] t;
      t = {drem[DIV_W-1:0], num[DIV_W-1]};
      if (t >= (DIV_W+1)'(root)) begin
        drem <= t - (DIV_W+1)'(root);
        num <= {num[DIV_W-2:0], 1'b1};
      end else begin
        drem <= t;
        num <= {num[DIV_W-2:0], 1'b0};
      end
      dcnt <= dcnt - CNT_W'(1);
    end
  end

  // status to the controller
  always_comb begin
    stat.mag_zero = (root == '0);
    stat.div_done = (dcnt == '0);
  end

  // incoming quaternion held for composition
  always_ff @(posedge clk) begin
    if (cmd.spin_q) begin
      spin[0] <= in_x; spin[1] <= in_y; spin[2] <= in_z; spin[3] <= in_w;
    end
  end

  // orientation store
  always_ff @(posedge clk) begin
    if (rst) begin
      orient[0] <= '0; orient[1] <= '0; orient[2] <= '0;
      orient[3] <= (ONE > 64'sd32767) ? 16'sh7fff : 16'(ONE);
    end else if (cmd.load_q) begin
      orient[0] <= in_x; orient[1] <= in_y; orient[2] <= in_z; orient[3] <= in_w;
    end else if (cmd.comp_wb) begin
      orient <= newq;
    end else if (cmd.div_wb) begin
      logic signed [63:0] qv;
      qv = dneg ? -64'(num) : 64'(num);
      orient[cmd.div_idx] <= (qv > 64'sd32767) ? 16'sh7fff :
                             (qv < -64'sd32768) ? 16'sh8000 : qv[15:0];
    end
  end
endmodule
`default_nettype wire

// ===== src/qoa_ctrl.sv =====
// controller: sequences load, compose, renormalize and matrix output
`timescale 1ns / 1ps
`default_nettype none
module qoa_ctrl (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            in_valid,
  output logic                 in_stall,
  input  wire logic            load_orientation,
  input  wire logic [7:0]      renorm_period,
  output logic                 out_valid,
  input  wire logic            out_stall,
  output logic [1:0]           row_index,
  output logic                 last_row,
  output qoa_pkg::qoa_cmd_t    cmd,
  input  wire qoa_pkg::qoa_stat_t stat
);
  import qoa_pkg::*;

  qoa_state_t state, state_next;
  logic [4:0] cnt, cnt_next;
  logic [7:0] compose_counter;
  logic       renorm;
  logic [1:0] row;
  logic       out_full;

  assign renorm = ({1'b0, compose_counter} + 9'd1) > {1'b0, renorm_period};

  // next state
  always_comb begin
    state_next = state;
    cnt_next = cnt + 5'd1;
    unique case (state)
      ST_IDLE: begin
        cnt_next = '0;
        if (in_valid) state_next = load_orientation ? ST_MAT : ST_LOAD;
      end
      ST_LOAD: begin cnt_next = '0; state_next = ST_COMP; end
      ST_COMP: if (cnt == 5'd16) state_next = ST_CWB;
      ST_CWB: begin cnt_next = '0; state_next = renorm ? ST_SUMSQ : ST_MAT; end
      ST_SUMSQ: if (cnt == 5'd5) begin cnt_next = '0; state_next = ST_SQRT; end
      ST_SQRT: if (cnt == 5'(SQRT_STEPS)) begin
        cnt_next = '0; state_next = stat.mag_zero ? ST_MAT : ST_DIV;
      end
      ST_DIV: begin
        cnt_next = cnt;
        if (cnt[4] && stat.div_done) begin
          state_next = (cnt[1:0] == 2'd3) ? ST_MAT : ST_DIV;
          cnt_next = {1'b0, 2'b00, cnt[1:0] + 2'd1};
          if (cnt[1:0] == 2'd3) cnt_next = '0;
        end else if (!cnt[4]) cnt_next = {1'b1, cnt[3:0]};
      end
      ST_MAT: if (cnt == 5'd10) begin cnt_next = '0; state_next = ST_OUT; end
      ST_OUT: begin
        cnt_next = '0;
        if (!out_full || !out_stall) begin
          if (row == 2'd2 && out_full && !out_stall) state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // command outputs
  always_comb begin
    cmd = '0;
    in_stall = !(state == ST_IDLE);
    unique case (state)
      ST_IDLE: begin
        cmd.spin_q = in_valid;
        cmd.load_q = in_valid && load_orientation;
      end
      ST_LOAD: ;
      ST_COMP: begin cmd.comp_step = (cnt < 5'd16); cmd.comp_idx = cnt[3:0]; end
      ST_CWB: cmd.comp_wb = 1'b1;
      ST_SUMSQ: begin
        cmd.sumsq_step = (cnt < 5'd4); cmd.sumsq_idx = cnt[1:0];
        cmd.sqrt_init = (cnt == 5'd5);
      end
      ST_SQRT: cmd.sqrt_step = (cnt < 5'(SQRT_STEPS));
      ST_DIV: begin
        cmd.div_idx = cnt[1:0];
        cmd.div_init = !cnt[4];
        cmd.div_step = cnt[4];
        cmd.div_wb = cnt[4] && stat.div_done;
      end
      ST_MAT: begin cmd.mat_step = (cnt < 5'd9); cmd.mat_idx = cnt[3:0]; end
      ST_OUT: begin
        cmd.row_sel = (out_full && !out_stall) ? row + 2'd1 : row;
        cmd.row_load = !out_full || (!out_stall && row != 2'd2);
      end
      default: ;
    endcase
  end

  // state and counters
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE; cnt <= '0; compose_counter <= '0;
      row <= '0; out_full <= 1'b0;
    end else begin
      state <= state_next; cnt <= cnt_next;
      if (state == ST_CWB) compose_counter <= renorm ? 8'd0 : compose_counter + 8'd1;
      if (state == ST_OUT) begin
        if (!out_full) begin out_full <= 1'b1; row <= '0; end
        else if (!out_stall) begin
          if (row == 2'd2) begin
            out_full <= 1'b0;
            row <= '0;
          end else row <= row + 2'd1;
        end
      end
    end
  end

  assign out_valid = out_full;
  assign row_index = row;
  assign last_row = (row == 2'd2);
endmodule
`default_nettype wire

// ===== src/quaternion_orientation_accumulator.sv =====
// top level: quaternion orientation accumulator with rotation matrix rows
//
// input channel: spin_x/y/z/w (Q2.14) and load_orientation, in_valid/in_stall.
// load replaces the stored orientation; otherwise the spin is composed with
// it using one shared 16x16 multiplier, sixteen products in turn.
// after renorm_period+1 compositions the orientation is divided by its
// magnitude: four squares, a 17-step square root, then four 31-step divides.
// every item yields three row items on out_valid/out_stall, row 2 flagged by
// last_row. the first row is valid once the matrix products are done; a load
// goes straight to them, a composition after its write-back and, if due, the
// renormalization (no divides when the magnitude is zero). one item is
// worked at a time; in_stall is high until the third row has been taken.
// a stalled receiver holds the current row; rows are never dropped.
// reset (rst, synchronous) sets the orientation to identity, the count to
// zero and renorm_period to 97. the user must write renorm_period with cfg_we/
// cfg_data only while the block is idle; the block does not enforce this.
`timescale 1ns / 1ps
`default_nettype none
module quaternion_orientation_accumulator #(
  parameter int FRAC_BITS = 14
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              cfg_we,
  input  wire logic [7:0]        cfg_data,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire logic signed [15:0] spin_x,
  input  wire logic signed [15:0] spin_y,
  input  wire logic signed [15:0] spin_z,
  input  wire logic signed [15:0] spin_w,
  input  wire logic              load_orientation,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output logic [1:0]             row_index,
  output logic signed [15:0]     col_zero,
  output logic signed [15:0]     col_one,
  output logic signed [15:0]     col_two,
  output logic                   last_row
);
  import qoa_pkg::*;

  qoa_cmd_t   cmd;
  qoa_stat_t  stat;
  logic [7:0] renorm_period;

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) renorm_period <= 8'd97;
    else if (cfg_we) renorm_period <= cfg_data;
  end

  qoa_ctrl u_ctrl (
    .clk, .rst, .in_valid, .in_stall, .load_orientation, .renorm_period,
    .out_valid, .out_stall, .row_index, .last_row, .cmd, .stat
  );

  qoa_datapath #(.FRAC_BITS(FRAC_BITS)) u_dp (
    .clk, .rst, .cmd, .stat,
    .in_x(spin_x), .in_y(spin_y), .in_z(spin_z), .in_w(spin_w),
    .row_c0(col_zero), .row_c1(col_one), .row_c2(col_two)
  );

  // checks
  a_lastrow: assert property (@(posedge clk) disable iff (rst)
    out_valid && last_row |-> row_index == 2'd2) else $error("last_row off row 2");
  a_busy: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> in_stall) else $error("input open during output");
  a_rowadv: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_stall && row_index == 2'd0 |=> out_valid && row_index == 2'd1)
    else $error("row sequence broken");
endmodule
`default_nettype wire
